// ===== src/reversible_circular_deque_assert.svh =====
// ============================================================================
// Assertion macros for the reversible circular deque
// Shared wrappers for concurrent assertions clocked on aclk.
// ============================================================================
`ifndef REVERSIBLE_CIRCULAR_DEQUE_ASSERT_SVH
`define REVERSIBLE_CIRCULAR_DEQUE_ASSERT_SVH

// Checked on every rising edge of aclk, disabled while aresetn is low.
`define RCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, also during reset.
`define RCD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== src/rcd_pkg.sv =====
// ============================================================================
// Reversible circular deque package
// Sizes, codes, command and status types and address helpers.
// ============================================================================
package rcd_pkg;

    localparam int CAPACITY = 256;
    localparam int DATA_W   = 32;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    localparam int OPCODE_W = 4;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 8;
    localparam int POS_W    = 9;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 9;

    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    localparam int S_TDATA_W  = 40;
    localparam int M_FIELDS_W = VALUE_W + POS_W + STATUS_W + LEN_W;
    localparam int M_TDATA_W  = 56;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 4'd0,
        OP_PUSH_FRONT = 4'd1,
        OP_POP_BACK   = 4'd2,
        OP_POP_FRONT  = 4'd3,
        OP_READ       = 4'd4,
        OP_WRITE      = 4'd5,
        OP_REVERSE    = 4'd6,
        OP_CLEAR      = 4'd7,
        OP_SEARCH     = 4'd8
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SEARCH,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic capture;
        logic srch_step;
        logic emit;
    } rcd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_read;
        logic is_search;
        logic srch_done;
        logic out_busy;
    } rcd_stat_t;

    // Adds an offset of at most CAPACITY to a slot number, modulo CAPACITY.
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                   input logic [CNT_W-1:0]  b);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
        if (sum >= (CNT_W + 1)'(CAPACITY)) begin
            sum = sum - (CNT_W + 1)'(CAPACITY);
        end
        return ADDR_W'(sum);
    endfunction

endpackage

// ===== src/rcd_ram.sv =====
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module rcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/rcd_ctrl.sv =====
// ============================================================================
// Deque controller
// Sequences accept, execute, read, search and result hand-off for one item.
// ============================================================================
module rcd_ctrl
    import rcd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_axis_tvalid,
    output logic      s_axis_tready,
    input  rcd_stat_t stat,
    output rcd_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (stat.is_search) begin
                    state_next = ST_SEARCH;
                end else if (stat.needs_read) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_READ: begin
                cmd.capture = 1'b1;
                state_next  = ST_DONE;
            end
            ST_SEARCH: begin
                cmd.srch_step = 1'b1;
                if (stat.srch_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Wait until the output register can take the result.
                if (!stat.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/rcd_dp.sv =====
// ============================================================================
// Deque datapath
// Ring pointers, slot store, search walk and the output register.
// ============================================================================
`include "reversible_circular_deque_assert.svh"

module rcd_dp
    import rcd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rcd_cmd_t              cmd,
    output rcd_stat_t             stat,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    input  logic [OPCODE_W-1:0]   s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    // Physical slot of a logical position.
    function automatic logic [ADDR_W-1:0] phys_of(input logic [CNT_W-1:0]  logical,
                                                  input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0]  cnt,
                                                  input logic              rev);
        logic [ADDR_W-1:0] slot;
        if (rev) begin
            slot = wrap_add(head, cnt - CNT_W'(1) - logical);
        end else begin
            slot = wrap_add(head, logical);
        end
        return slot;
    endfunction

    op_t                 op_reg;
    logic [DATA_W-1:0]   val_reg;
    logic [INDEX_W-1:0]  idx_reg;

    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                rev_reg, rev_next;

    logic [VALUE_W-1:0]  res_data_reg;
    logic [POS_W-1:0]    res_pos_reg;
    status_t             res_status_reg;
    status_t             status_next;
    logic [POS_W-1:0]    pos_next;

    logic [CNT_W-1:0]    issue_reg;
    logic [CNT_W-1:0]    cmp_idx_reg;
    logic                cmp_valid_reg;

    logic                out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_tdata_reg;

    logic                is_full, is_empty, bad_idx, hit;
    logic [ADDR_W-1:0]   head_dec, back_addr, last_addr, idx_addr;
    logic [ADDR_W-1:0]   exec_rd_addr, rd_addr, wr_addr;
    logic                wr_en;
    logic [DATA_W-1:0]   rd_data;
    logic                needs_read, is_search;

    assign is_full   = count_reg >= CNT_W'(CAPACITY);
    assign is_empty  = count_reg == '0;
    assign bad_idx   = CMP_W'(idx_reg) >= CMP_W'(count_reg);
    assign head_dec  = (head_reg == '0) ? ADDR_W'(CAPACITY - 1) : head_reg - ADDR_W'(1);
    assign back_addr = wrap_add(head_reg, count_reg);
    assign last_addr = wrap_add(head_reg, count_reg - CNT_W'(1));
    assign idx_addr  = phys_of(CNT_W'(idx_reg), head_reg, count_reg, rev_reg);

    always_comb begin
        head_next    = head_reg;
        count_next   = count_reg;
        rev_next     = rev_reg;
        wr_en        = 1'b0;
        wr_addr      = head_reg;
        exec_rd_addr = '0;
        status_next  = STAT_OK;
        pos_next     = '0;
        needs_read   = 1'b0;
        is_search    = 1'b0;
        case (op_reg)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (is_full) begin
                    status_next = STAT_FULL;
                end else if ((op_reg == OP_PUSH_BACK) != rev_reg) begin
                    wr_en      = 1'b1;
                    wr_addr    = back_addr;
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = head_dec;
                    head_next  = head_dec;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
                if (is_empty) begin
                    status_next = STAT_EMPTY;
                end else if ((op_reg == OP_POP_BACK) != rev_reg) begin
                    needs_read   = 1'b1;
                    exec_rd_addr = last_addr;
                    count_next   = count_reg - CNT_W'(1);
                end else begin
                    needs_read   = 1'b1;
                    exec_rd_addr = head_reg;
                    head_next    = wrap_add(head_reg, CNT_W'(1));
                    count_next   = count_reg - CNT_W'(1);
                end
            end
            OP_READ: begin
                needs_read = 1'b1;
                if (bad_idx) begin
                    exec_rd_addr = '0;
                    status_next  = STAT_BAD_INDEX;
                end else begin
                    exec_rd_addr = idx_addr;
                end
            end
            OP_WRITE: begin
                wr_en = 1'b1;
                if (bad_idx) begin
                    wr_addr     = '0;
                    status_next = STAT_BAD_INDEX;
                end else begin
                    wr_addr = idx_addr;
                end
            end
            OP_REVERSE: begin
                rev_next = !rev_reg;
            end
            OP_CLEAR: begin
                head_next  = '0;
                count_next = '0;
            end
            OP_SEARCH: begin
                is_search = 1'b1;
                pos_next  = '1;
            end
            default: begin
                head_next = head_reg;
            end
        endcase
    end

    // During a search the read port walks the logical positions in order.
    assign rd_addr = cmd.srch_step ? phys_of(issue_reg, head_reg, count_reg, rev_reg)
                                   : exec_rd_addr;

    rcd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (wr_en && cmd.exec),
        .wr_addr (wr_addr),
        .wr_data (val_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign hit = cmp_valid_reg && (rd_data == val_reg);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (cmd.exec) begin
                head_reg      <= head_next;
                count_reg     <= count_next;
                rev_reg       <= rev_next;
                cmp_valid_reg <= 1'b0;
            end else if (cmd.srch_step) begin
                cmp_valid_reg <= issue_reg < count_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= op_t'(s_axis_tuser);
            val_reg <= DATA_W'(s_axis_tdata[VALUE_W-1:0]);
            idx_reg <= s_axis_tdata[VALUE_W +: INDEX_W];
        end
        if (cmd.exec) begin
            res_status_reg <= status_next;
            res_pos_reg    <= pos_next;
            res_data_reg   <= '0;
            issue_reg      <= '0;
        end
        if (cmd.capture) begin
            res_data_reg <= VALUE_W'(rd_data);
        end
        if (cmd.srch_step) begin
            if (issue_reg < count_reg) begin
                issue_reg   <= issue_reg + CNT_W'(1);
                cmp_idx_reg <= issue_reg;
            end
            if (hit) begin
                res_pos_reg <= POS_W'(cmp_idx_reg);
            end
        end
        if (cmd.emit) begin
            out_tdata_reg <= {{M_PAD_W{1'b0}}, LEN_W'(count_reg), res_status_reg,
                              res_pos_reg, res_data_reg};
        end
    end

    assign stat.needs_read = needs_read;
    assign stat.is_search  = is_search;
    assign stat.srch_done  = hit || (!cmp_valid_reg && (issue_reg >= count_reg));
    assign stat.out_busy   = out_valid_reg && !m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tdata_reg;

    `RCD_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY), "element count above capacity")
    `RCD_ASSERT(a_head_bound, head_reg <= ADDR_W'(CAPACITY - 1), "head outside the store")
    `RCD_ASSERT(a_emit_free, cmd.emit |-> !(out_valid_reg && !m_axis_tready), "result overwritten")
    `RCD_ASSERT(a_push_grows, cmd.exec && (op_reg == OP_PUSH_BACK || op_reg == OP_PUSH_FRONT) && !is_full |=> count_reg == $past(count_reg) + CNT_W'(1), "push did not add an element")

endmodule

// ===== src/reversible_circular_deque.sv =====
// ============================================================================
// Reversible circular deque
// Fixed-capacity ring-buffer deque with a logical reverse flag.
// ============================================================================
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: value, index; tuser: opcode
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: data, position, status, length
//
// Push, write, reverse, clear, unused opcodes and refused pops take these steps to a result:
// accept, an execute step with the memory write, and the output register load.
// Pop and read add a step for the registered read of the slot memory.
// Search walks the store through the single read port, one element a cycle, and ends
// at the first match, or after the last live element when nothing matches.
// Reset clears the pointers and the reverse flag at once; the slot memory is not cleared.
// One item is in work at a time; the next is accepted once the previous result sits in
// the output register, and a stalled m_axis side only holds the block at its final step.
module reversible_circular_deque
    import rcd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input items.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // From bit 0: value (32), index (8).
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // From bit 0: opcode (4).
    input  logic [OPCODE_W-1:0]  s_axis_tuser,
    // Result items.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // From bit 0: data (32), position (9), status (2), length (9), zero fill (4).
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    // The controller and the datapath talk only through these two groups.
    rcd_cmd_t  cmd;
    rcd_stat_t stat;

    rcd_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // The datapath holds the ring pointers, the slot memory and the output register.
    rcd_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== bench/tb.sv =====
// ============================================================================
// Testbench for the reversible circular deque
// Drives push, pop, indexed access, reverse, clear and search items with
// random bursts and output stalls, and checks every result item against a
// cycle-free predictor in the bench or the result typed in a directed row.
// ============================================================================
`timescale 1ns / 1ps

module tb
    import rcd_pkg::*;
;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int NUM_RANDOM   = 1800;
    localparam int DIR_N        = 26;
    localparam int MAX_GAP      = 12;
    localparam int MAX_STALL    = 16;
    localparam int DRAIN_CYCLES = 16;
    // Worst case per item: a full-length search, the longest gap and stall.
    localparam int CYCLE_LIMIT  =
        (NUM_RANDOM + DIR_N) * (CAPACITY + 8 + MAX_GAP + MAX_STALL) * 4;

    localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 4'd9;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 4'd15;
    localparam logic [POS_W-1:0]    POS_NONE     = '1;

    localparam logic [7:0][VALUE_W-1:0] VAL_POOL = {
        32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
        32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0003, 32'hFFFF_FFFE
    };

    // Same layout as m_axis_tdata, so a result word casts straight into it.
    typedef struct packed {
        logic [M_PAD_W-1:0]  fill;
        logic [LEN_W-1:0]    length;
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [VALUE_W-1:0]  data;
    } deque_result_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [VALUE_W-1:0]  value;
        logic [INDEX_W-1:0]  index;
        logic                known;    // expectation typed in the row
        deque_result_t       want;
    } dir_row_t;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} load_mode_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // From bit 0: value (32), index (8).
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // From bit 0: opcode (4).
    logic [OPCODE_W-1:0]  s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // From bit 0: data (32), position (9), status (2), length (9), zero fill (4).
    logic [M_TDATA_W-1:0] m_axis_tdata;

    reversible_circular_deque dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    int unsigned cycle_cnt = 0;
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // ------------------------------------------------------------------
    // Shadow deque: store, front slot, element count and order flag.
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0] store [CAPACITY];
    int unsigned        front_slot    = 0;
    int unsigned        elem_cnt      = 0;
    bit                 order_flipped = 1'b0;
    bit                 slot0_written = 1'b0;

    int unsigned n_search = 0, n_full = 0, n_empty = 0, n_badidx = 0;
    int unsigned n_filled = 0, n_drained = 0, n_flips = 0;
    int unsigned items_sent = 0, results_checked = 0, errors = 0;
    int unsigned burst_left = 0;

    deque_result_t awaited_results [$];

    // Physical slot of a logical position; positions count from the back
    // while the order is flipped.
    function automatic int unsigned logical_slot(input int unsigned lpos);
        if (order_flipped) begin
            return (front_slot + elem_cnt - 1 - lpos) % CAPACITY;
        end
        return (front_slot + lpos) % CAPACITY;
    endfunction

    function automatic void store_write(input int unsigned slot, input logic [VALUE_W-1:0] v);
        store[slot] = v;
        if (slot == 0) begin
            slot0_written = 1'b1;
        end
    endfunction

    // Applies one item to the shadow deque and returns the result it gives.
    function automatic deque_result_t predict_deque_op(input logic [OPCODE_W-1:0] op,
                                                       input logic [VALUE_W-1:0]  val,
                                                       input logic [INDEX_W-1:0]  idx);
        deque_result_t r;
        bit            found;
        r = '0;
        found = 1'b0;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (elem_cnt >= CAPACITY) begin
                    r.status = STAT_FULL;
                    n_full++;
                end else begin
                    // With the order flipped, a logical push at the back lands
                    // at the physical front, and the other way round.
                    if ((op == OP_PUSH_BACK) != order_flipped) begin
                        store_write((front_slot + elem_cnt) % CAPACITY, val);
                    end else begin
                        front_slot = (front_slot + CAPACITY - 1) % CAPACITY;
                        store_write(front_slot, val);
                    end
                    elem_cnt++;
                    if (elem_cnt == CAPACITY) begin
                        n_filled++;
                    end
                end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
                if (elem_cnt == 0) begin
                    r.status = STAT_EMPTY;
                    n_empty++;
                end else begin
                    if ((op == OP_POP_BACK) != order_flipped) begin
                        r.data = store[(front_slot + elem_cnt - 1) % CAPACITY];
                    end else begin
                        r.data = store[front_slot];
                        front_slot = (front_slot + 1) % CAPACITY;
                    end
                    elem_cnt--;
                    if (elem_cnt == 0) begin
                        n_drained++;
                    end
                end
            end
            OP_READ: begin
                // A bad index answers with whatever sits in physical slot 0.
                if (idx >= elem_cnt) begin
                    r.data   = store[0];
                    r.status = STAT_BAD_INDEX;
                    n_badidx++;
                end else begin
                    r.data = store[logical_slot(idx)];
                end
            end
            OP_WRITE: begin
                // A bad index still writes, into physical slot 0.
                if (idx >= elem_cnt) begin
                    store_write(0, val);
                    r.status = STAT_BAD_INDEX;
                    n_badidx++;
                end else begin
                    store_write(logical_slot(idx), val);
                end
            end
            OP_REVERSE: begin
                order_flipped = !order_flipped;
                n_flips++;
            end
            OP_CLEAR: begin
                // The order flag and the stored values survive a clear.
                front_slot = 0;
                elem_cnt   = 0;
                n_drained++;
            end
            OP_SEARCH: begin
                r.position = POS_NONE;
                n_search++;
                for (int unsigned i = 0; i < elem_cnt; i++) begin
                    if (!found && store[logical_slot(i)] == val) begin
                        r.position = POS_W'(i);
                        found = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.length = LEN_W'(elem_cnt);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [OPCODE_W-1:0] op,
                             input logic [VALUE_W-1:0]  val,
                             input logic [INDEX_W-1:0]  idx,
                             input logic                known,
                             input deque_result_t       typed_want);
        deque_result_t want;
        int unsigned   gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            // Now and then a long burst with no idling at all.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {idx, val};
        s_axis_tuser  <= op;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        want = predict_deque_op(op, val, idx);
        if (known) begin
            want = typed_want;
        end
        awaited_results.push_back(want);
        burst_left--;
        items_sent++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: a rotating stall pattern, replaced every so often.
    // ------------------------------------------------------------------
    logic [15:0] ready_pat = 16'hFFFF;
    int unsigned pat_left  = 0;

    always @(posedge aclk) begin : ready_gen
        logic [15:0] pat;
        pat = ready_pat;
        if (pat_left == 0) begin
            case ($urandom_range(0, 3))
                0: pat = '1;
                1: pat = 16'($urandom() & $urandom()) | 16'h0101;
                default: pat = 16'($urandom()) | 16'h0101;
            endcase
            pat_left <= $urandom_range(32, 256);
        end else begin
            pat_left <= pat_left - 1;
        end
        m_axis_tready <= pat[0];
        ready_pat     <= {pat[0], pat[15:1]};
    end

    // ------------------------------------------------------------------
    // Result checking against the oldest awaited result.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        deque_result_t got;
        deque_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = deque_result_t'(m_axis_tdata);
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result item, expected none, got %h",
                         $time, m_axis_tdata);
                errors++;
            end else begin
                want = awaited_results.pop_front();
                check_field("data", want.data, got.data);
                check_field("position", VALUE_W'(want.position), VALUE_W'(got.position));
                check_field("status", VALUE_W'(want.status), VALUE_W'(got.status));
                check_field("length", VALUE_W'(want.length), VALUE_W'(got.length));
                check_field("zero fill", VALUE_W'(want.fill), VALUE_W'(got.fill));
                results_checked++;
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) @(posedge aclk);
        $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus: directed rows first, then random load phases.
    // ------------------------------------------------------------------
    dir_row_t dir_rows [DIR_N];

    initial begin : stimulus
        load_mode_t          mode;
        int unsigned         mix_left;
        int unsigned         roll;
        logic [OPCODE_W-1:0] op;
        logic [VALUE_W-1:0]  val;
        logic [INDEX_W-1:0]  idx;

        // Slot 0 gets a value first, so a bad-index read never sees an
        // unwritten slot.
        dir_rows = '{
            '{OP_WRITE,      32'hDEAD_BEEF, 8'd0,   1'b1,
              '{4'd0, 9'd0, STAT_BAD_INDEX, 9'd0, 32'h0}},
            '{OP_READ,       32'h0,         8'd0,   1'b1,
              '{4'd0, 9'd0, STAT_BAD_INDEX, 9'd0, 32'hDEAD_BEEF}},
            '{OP_POP_BACK,   32'h0,         8'd0,   1'b1,
              '{4'd0, 9'd0, STAT_EMPTY,     9'd0, 32'h0}},
            '{OP_POP_FRONT,  32'h0,         8'd0,   1'b1,
              '{4'd0, 9'd0, STAT_EMPTY,     9'd0, 32'h0}},
            // Slot 0 holds the key, but nothing is live, so no match.
            '{OP_SEARCH,     32'hDEAD_BEEF, 8'd0,   1'b1,
              '{4'd0, 9'd0, STAT_OK,        POS_NONE, 32'h0}},
            '{OP_PUSH_BACK,  32'h7FFF_FFFF, 8'd0,   1'b1,
              '{4'd0, 9'd1, STAT_OK,        9'd0, 32'h0}},
            '{OP_PUSH_FRONT, 32'h8000_0000, 8'd0,   1'b1,
              '{4'd0, 9'd2, STAT_OK,        9'd0, 32'h0}},
            '{OP_PUSH_BACK,  32'h0,         8'd0,   1'b1,
              '{4'd0, 9'd3, STAT_OK,        9'd0, 32'h0}},
            '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 8'd0,   1'b1,
              '{4'd0, 9'd4, STAT_OK,        9'd0, 32'h0}},
            '{OP_READ,       32'h0,         8'd0,   1'b1,
              '{4'd0, 9'd4, STAT_OK,        9'd0, 32'hFFFF_FFFF}},
            '{OP_READ,       32'h0,         8'd3,   1'b0, '0},
            '{OP_READ,       32'h0,         8'd255, 1'b0, '0},
            '{OP_WRITE,      32'h1234_5678, 8'd1,   1'b0, '0},
            '{OP_REVERSE,    32'h0,         8'd0,   1'b0, '0},
            '{OP_READ,       32'h0,         8'd0,   1'b0, '0},
            '{OP_SEARCH,     32'h7FFF_FFFF, 8'd0,   1'b0, '0},
            '{OP_PUSH_BACK,  32'h5555_5555, 8'd0,   1'b0, '0},
            '{OP_PUSH_FRONT, 32'hAAAA_AAAA, 8'd0,   1'b0, '0},
            '{OP_POP_BACK,   32'h0,         8'd0,   1'b0, '0},
            '{OP_POP_FRONT,  32'h0,         8'd0,   1'b0, '0},
            '{OP_WRITE,      32'h0F0F_0F0F, 8'd200, 1'b0, '0},
            '{OP_UNUSED_HI,  32'hFFFF_FFFF, 8'd255, 1'b0, '0},
            '{OP_UNUSED_LO,  32'h0,         8'd0,   1'b0, '0},
            '{OP_REVERSE,    32'h0,         8'd0,   1'b0, '0},
            '{OP_CLEAR,      32'h0,         8'd0,   1'b1,
              '{4'd0, 9'd0, STAT_OK,        9'd0, 32'h0}},
            '{OP_SEARCH,     32'h1234_5678, 8'd0,   1'b1,
              '{4'd0, 9'd0, STAT_OK,        POS_NONE, 32'h0}}
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIR_N; r++) begin
            send_item(dir_rows[r].op, dir_rows[r].value, dir_rows[r].index,
                      dir_rows[r].known, dir_rows[r].want);
        end

        // Random part: fill phases run the deque up to full and keep pushing
        // a little, drain phases run it down to empty, mixed phases do a bit
        // of everything including clears and unused opcodes.
        mode     = MODE_FILL;
        mix_left = 0;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            case (mode)
                MODE_FILL: begin
                    if (elem_cnt == CAPACITY && $urandom_range(0, 3) == 0) begin
                        mode     = ($urandom_range(0, 1) == 0) ? MODE_DRAIN : MODE_MIX;
                        mix_left = $urandom_range(40, 120);
                    end
                end
                MODE_DRAIN: begin
                    if (elem_cnt == 0 && $urandom_range(0, 3) == 0) begin
                        mode     = ($urandom_range(0, 1) == 0) ? MODE_FILL : MODE_MIX;
                        mix_left = $urandom_range(40, 120);
                    end
                end
                default: begin
                    if (mix_left == 0) begin
                        mode = ($urandom_range(0, 1) == 0) ? MODE_FILL : MODE_DRAIN;
                    end else begin
                        mix_left--;
                    end
                end
            endcase

            roll = $urandom_range(0, 99);
            case (mode)
                MODE_FILL: begin
                    if (roll < 85) begin
                        op = ($urandom_range(0, 1) == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                    end else if (roll < 90) begin
                        op = OP_READ;
                    end else if (roll < 94) begin
                        op = OP_WRITE;
                    end else if (roll < 97) begin
                        op = OP_SEARCH;
                    end else begin
                        op = OP_REVERSE;
                    end
                end
                MODE_DRAIN: begin
                    if (roll < 80) begin
                        op = ($urandom_range(0, 1) == 0) ? OP_POP_BACK : OP_POP_FRONT;
                    end else if (roll < 88) begin
                        op = OP_READ;
                    end else if (roll < 93) begin
                        op = OP_WRITE;
                    end else if (roll < 96) begin
                        op = OP_SEARCH;
                    end else begin
                        op = OP_REVERSE;
                    end
                end
                default: begin
                    if (roll < 24) begin
                        op = ($urandom_range(0, 1) == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                    end else if (roll < 46) begin
                        op = ($urandom_range(0, 1) == 0) ? OP_POP_BACK : OP_POP_FRONT;
                    end else if (roll < 62) begin
                        op = OP_READ;
                    end else if (roll < 76) begin
                        op = OP_WRITE;
                    end else if (roll < 84) begin
                        op = OP_SEARCH;
                    end else if (roll < 90) begin
                        op = OP_REVERSE;
                    end else if (roll < 93) begin
                        op = OP_CLEAR;
                    end else begin
                        op = OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
                    end
                end
            endcase

            // Mostly a live position, sometimes any index at all.
            if (elem_cnt != 0 && $urandom_range(0, 9) != 0) begin
                idx = INDEX_W'($urandom_range(0, elem_cnt - 1));
            end else begin
                idx = INDEX_W'($urandom_range(0, 255));
            end

            // Values repeat often enough that searches hit as well as miss.
            roll = $urandom_range(0, 9);
            if (roll >= 8 && elem_cnt != 0) begin
                val = store[logical_slot($urandom_range(0, elem_cnt - 1))];
            end else if (roll >= 6) begin
                val = VAL_POOL[$urandom_range(0, 7)];
            end else begin
                val = $urandom();
            end

            if (op == OP_READ && idx >= elem_cnt && !slot0_written) begin
                op = OP_WRITE;
            end

            send_item(op, val, idx, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d items and checked %0d results: %0d searches, %0d refused pushes,",
                 items_sent, results_checked, n_search, n_full);
        $display("%0d refused pops, %0d bad indexes; full %0d times, emptied %0d, reversed %0d.",
                 n_empty, n_badidx, n_filled, n_drained, n_flips);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
